// File: sv/pge_pkg.sv
// ----------------------------------------------------------------------------
// pge_pkg: shared types and constants of the gradient energy map
// Holds the pixel and line store entry types, the configuration register
// indexes, the port widths and the channel distance function.
// ----------------------------------------------------------------------------
package pge_pkg;

   // Size limits of the incoming frame.
   localparam int PGE_MAX_WIDTH  = 2048;
   localparam int PGE_MAX_HEIGHT = 4095;

   // Field widths.
   localparam int CHAN_W     = 8;
   localparam int DIST_W     = 10;
   localparam int ENERGY_W   = 12;
   localparam int ROW_OUT_W  = 12;
   localparam int COL_OUT_W  = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - ROW_OUT_W - COL_OUT_W - ENERGY_W;

   // Configuration port.
   localparam int CSR_DATA_W  = 12;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [CSR_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // One column of the line store: the row two above and the row above.
   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } line_entry_type;

   // Sum of the absolute channel differences of two pixels.
   function automatic logic [DIST_W-1:0] pix_dist(input pixel_type p, input pixel_type q);
      logic [CHAN_W-1:0] dr;
      logic [CHAN_W-1:0] dg;
      logic [CHAN_W-1:0] db;
      dr = (p.red   > q.red)   ? p.red   - q.red   : q.red   - p.red;
      dg = (p.green > q.green) ? p.green - q.green : q.green - p.green;
      db = (p.blue  > q.blue)  ? p.blue  - q.blue  : q.blue  - p.blue;
      return DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);
   endfunction

endpackage

// File: sv/pixel_gradient_energy_map.sv
// ----------------------------------------------------------------------------
// pixel_gradient_energy_map: streaming L1 gradient energy of an RGB frame
// Pixels enter in raster order; each pixel's energy is the sum of the
// absolute channel differences to its in-frame four neighbors.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock unless the pipeline stalls. Pixel (r,c) is
// reported when pixel (r+1,c) arrives, so all rows above the last give one
// result per pixel and run at one pixel per clock while rsp_tready is high.
// On the last row each pixel but the first also reports its left neighbor,
// and the final pixel reports itself; the single result register then
// holds up the input while a pixel's reports are handed out. Each report
// passes through the first stage, the second stage and the result register.
// The two previous rows live in one memory of MAX_WIDTH entries that is read
// one column ahead of the arriving pixel; there is no clearing pass after
// reset. Writing either size register restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module pixel_gradient_energy_map #(
   parameter int MAX_WIDTH  = pge_pkg::PGE_MAX_WIDTH,
   parameter int MAX_HEIGHT = pge_pkg::PGE_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   // Pixel items.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // From bit 0: red[7:0], green[15:8], blue[23:16].
   input  logic [pge_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Energy items.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // From bit 0: pixel_row[11:0], pixel_col[22:12], energy[34:23], zero pad.
   output logic [pge_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast,    // run_last
   output logic                             rsp_tuser,    // frame_last
   // Configuration writes.
   input  logic                             csr_wr_en,
   input  logic [pge_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pge_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import pge_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam logic [CW-1:0] LAST_COL_MAX = CW'(MAX_WIDTH - 1);
   localparam logic [RW-1:0] LAST_ROW_MAX = RW'(MAX_HEIGHT - 1);

   // Position and neighbor flags of the pixel in the first stage.
   typedef struct packed {
      logic [RW-1:0] row;
      logic [CW-1:0] col;
      logic          has_a;     // report of the pixel above
      logic          has_b;     // report of the pixel to the left
      logic          has_c;     // report of the final pixel itself
      logic          up1;       // a row exists above
      logic          up2;       // two rows exist above
      logic          left1;     // a column exists to the left
      logic          left2;     // two columns exist to the left
      logic          right1;    // a column exists to the right
   } s1_ctl_type;

   // Pending reports of the item in the second stage.
   typedef struct packed {
      logic c;
      logic b;
      logic a;
   } pend_type;

   // Masked neighbor distances for the three possible reports.
   typedef struct packed {
      logic [DIST_W-1:0] au;
      logic [DIST_W-1:0] ad;
      logic [DIST_W-1:0] al;
      logic [DIST_W-1:0] ar;
      logic [DIST_W-1:0] bu;
      logic [DIST_W-1:0] bl;
      logic [DIST_W-1:0] br;
      logic [DIST_W-1:0] cu;
      logic [DIST_W-1:0] cl;
   } dist_set_type;

   typedef struct packed {
      logic                 frame_last;
      logic                 run_last;
      logic [ENERGY_W-1:0]  energy;
      logic [COL_OUT_W-1:0] pixel_col;
      logic [ROW_OUT_W-1:0] pixel_row;
   } result_type;

   // Configuration and position state.
   logic [CSR_DATA_W-1:0] fw_ff;
   logic [CSR_DATA_W-1:0] fh_ff;
   logic [CSR_DATA_W-1:0] fw_m1;
   logic [CSR_DATA_W-1:0] fh_m1;
   logic [CW-1:0]         last_col;
   logic [RW-1:0]         last_row;
   logic [CW-1:0]         col_ff;
   logic [CW-1:0]         col_in;
   logic [RW-1:0]         row_ff;
   logic [RW-1:0]         row_in;
   logic                  at_last_col;
   logic                  at_last_row;

   // Input side.
   pixel_type      req_px;
   logic           req_accept;
   line_entry_type mem_rd;
   line_entry_type mem_wr;

   // Pixel history along the row.
   pixel_type prev_n_ff;
   pixel_type p1_ff;
   pixel_type p2_ff;

   // First stage.
   logic       s1_valid_ff;
   logic       s1_valid_in;
   s1_ctl_type s1_ctl_ff;
   pixel_type  s1_px_ff;
   pixel_type  s1_nc_ff;
   pixel_type  s1_oc_ff;
   pixel_type  s1_nl_ff;
   pixel_type  s1_p1_ff;
   pixel_type  s1_p2_ff;
   logic       s1_adv;

   logic [DIST_W-1:0] d_nd;
   logic [DIST_W-1:0] d_br;
   dist_set_type      dist_new;
   pend_type          pend_new;

   // Second stage.
   logic          s2_valid_ff;
   logic          s2_valid_in;
   pend_type      s2_pend_ff;
   pend_type      s2_pend_in;
   pend_type      s2_sel;
   pend_type      s2_rest;
   dist_set_type  s2_dist_ff;
   logic [RW-1:0] s2_row_ff;
   logic [CW-1:0] s2_col_ff;
   logic          s2_last;
   logic          s2_issue;
   logic          s2_free;
   result_type    s2_result;

   // Result register.
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   logic       out_load;

   // ------------------------------------------------------------------------
   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= FRAME_WIDTH_RESET;
         fh_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  fw_ff <= csr_wr_data;
            CSR_FRAME_HEIGHT: fh_ff <= csr_wr_data;
         endcase
      end
   end

   // Clamp the frame size to 1..MAX and take the last column and row.
   assign fw_m1 = fw_ff - 1'b1;
   assign fh_m1 = fh_ff - 1'b1;

   always_comb begin
      if (fw_ff == '0) begin
         last_col = '0;
      end else if (fw_ff > MAX_WIDTH) begin
         last_col = LAST_COL_MAX;
      end else begin
         last_col = CW'(fw_m1);
      end
      if (fh_ff == '0) begin
         last_row = '0;
      end else if (fh_ff > MAX_HEIGHT) begin
         last_row = LAST_ROW_MAX;
      end else begin
         last_row = RW'(fh_m1);
      end
   end

   assign at_last_col = (col_ff == last_col);
   assign at_last_row = (row_ff == last_row);

   // ------------------------------------------------------------------------
   // Handshake of the input side.
   assign req_px.red   = req_tdata[7:0];
   assign req_px.green = req_tdata[15:8];
   assign req_px.blue  = req_tdata[23:16];

   assign req_tready = !s1_valid_ff || s2_free;
   assign req_accept = req_tvalid && req_tready;

   // Row and column of the next pixel; a register write restarts the frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_wr_en) begin
         col_in = '0;
         row_in = '0;
      end else if (req_accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------------
   // Line store: the entry of the next column is always being read, so the
   // arriving pixel finds its column ready, and while it sits in the first
   // stage the read data holds the right neighbor of the pixel above it.
   assign mem_wr.older = mem_rd.newer;
   assign mem_wr.newer = req_px;

   pge_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (col_ff),
      .wr_data (mem_wr),
      .rd_addr (col_in),
      .rd_data (mem_rd)
   );

   // Recent pixels of the row above and of the current row.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         prev_n_ff <= mem_rd.newer;
         p1_ff     <= req_px;
         p2_ff     <= p1_ff;
      end
   end

   // ------------------------------------------------------------------------
   // First stage: the item with its column and its neighbors.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s2_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_px_ff         <= req_px;
         s1_nc_ff         <= mem_rd.newer;
         s1_oc_ff         <= mem_rd.older;
         s1_nl_ff         <= prev_n_ff;
         s1_p1_ff         <= p1_ff;
         s1_p2_ff         <= p2_ff;
         s1_ctl_ff.row    <= row_ff;
         s1_ctl_ff.col    <= col_ff;
         s1_ctl_ff.has_a  <= (row_ff != '0);
         s1_ctl_ff.has_b  <= at_last_row && (col_ff != '0);
         s1_ctl_ff.has_c  <= at_last_row && at_last_col;
         s1_ctl_ff.up1    <= (row_ff != '0);
         s1_ctl_ff.up2    <= (row_ff > RW'(1));
         s1_ctl_ff.left1  <= (col_ff != '0);
         s1_ctl_ff.left2  <= (col_ff > CW'(1));
         s1_ctl_ff.right1 <= !at_last_col;
      end
   end

   // Neighbor distances; the right neighbor of the pixel above comes from the line store read.
   assign d_nd = pix_dist(s1_nc_ff, s1_px_ff);
   assign d_br = pix_dist(s1_p1_ff, s1_px_ff);

   always_comb begin
      dist_new.au = s1_ctl_ff.up2    ? pix_dist(s1_nc_ff, s1_oc_ff)     : '0;
      dist_new.ad = d_nd;
      dist_new.al = s1_ctl_ff.left1  ? pix_dist(s1_nc_ff, s1_nl_ff)     : '0;
      dist_new.ar = s1_ctl_ff.right1 ? pix_dist(s1_nc_ff, mem_rd.newer) : '0;
      dist_new.bu = s1_ctl_ff.up1    ? pix_dist(s1_p1_ff, s1_nl_ff)     : '0;
      dist_new.bl = s1_ctl_ff.left2  ? pix_dist(s1_p1_ff, s1_p2_ff)     : '0;
      dist_new.br = d_br;
      dist_new.cu = s1_ctl_ff.up1    ? d_nd : '0;
      dist_new.cl = s1_ctl_ff.left1  ? d_br : '0;
      pend_new.a  = s1_ctl_ff.has_a;
      pend_new.b  = s1_ctl_ff.has_b;
      pend_new.c  = s1_ctl_ff.has_c;
   end

   assign s1_adv = s1_valid_ff && s2_free;

   // ------------------------------------------------------------------------
   // Second stage: hands out the item's reports in raster order, one a cycle while the result register can load.
   assign s2_sel.a = s2_pend_ff.a;
   assign s2_sel.b = s2_pend_ff.b && !s2_pend_ff.a;
   assign s2_sel.c = s2_pend_ff.c && !s2_pend_ff.a && !s2_pend_ff.b;
   assign s2_rest  = s2_pend_ff & ~s2_sel;
   assign s2_last  = (s2_rest == '0);
   assign s2_issue = s2_valid_ff && out_load;
   assign s2_free  = !s2_valid_ff || (s2_issue && s2_last);

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_pend_in  = s2_pend_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff && (pend_new != '0);
         s2_pend_in  = pend_new;
      end else if (s2_issue) begin
         s2_pend_in  = s2_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_pend_ff  <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s2_pend_ff  <= s2_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_dist_ff <= dist_new;
         s2_row_ff  <= s1_ctl_ff.row;
         s2_col_ff  <= s1_ctl_ff.col;
      end
   end

   // Energy, row and column of the report being handed out.
   always_comb begin
      s2_result.run_last   = s2_last;
      s2_result.frame_last = s2_sel.c;
      if (s2_sel.a) begin
         s2_result.energy    = ENERGY_W'(s2_dist_ff.au) + ENERGY_W'(s2_dist_ff.ad)
                             + ENERGY_W'(s2_dist_ff.al) + ENERGY_W'(s2_dist_ff.ar);
         s2_result.pixel_row = ROW_OUT_W'(s2_row_ff - 1'b1);
         s2_result.pixel_col = COL_OUT_W'(s2_col_ff);
      end else if (s2_sel.b) begin
         s2_result.energy    = ENERGY_W'(s2_dist_ff.bu) + ENERGY_W'(s2_dist_ff.bl)
                             + ENERGY_W'(s2_dist_ff.br);
         s2_result.pixel_row = ROW_OUT_W'(s2_row_ff);
         s2_result.pixel_col = COL_OUT_W'(s2_col_ff - 1'b1);
      end else begin
         s2_result.energy    = ENERGY_W'(s2_dist_ff.cu) + ENERGY_W'(s2_dist_ff.cl);
         s2_result.pixel_row = ROW_OUT_W'(s2_row_ff);
         s2_result.pixel_col = COL_OUT_W'(s2_col_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Result register.
   assign out_load = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_issue) begin
         out_ff <= s2_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, out_ff.energy, out_ff.pixel_col, out_ff.pixel_row};
   assign rsp_tlast  = out_ff.run_last;
   assign rsp_tuser  = out_ff.frame_last;

   // ------------------------------------------------------------------------
   // Checks.
   a_frame_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame_last item is not the last of its run");

   a_s2_has_work: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_pend_ff != '0))
      else $error("second stage holds an item with no pending report");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col)
      else $error("column counter beyond the last column");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item did not enter the first stage");

endmodule

// File: sv/pge_line_store.sv
// ----------------------------------------------------------------------------
// pge_line_store: two-row line store
// One synchronous memory with one entry per column. Each entry holds the
// pixels of the two previous rows. The read data is registered, and a write
// to the address being read is forwarded into the read register.
// ----------------------------------------------------------------------------
module pge_line_store #(
   parameter int DEPTH = pge_pkg::PGE_MAX_WIDTH,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [AW-1:0]           wr_addr,
   input  pge_pkg::line_entry_type wr_data,
   input  logic [AW-1:0]           rd_addr,
   output pge_pkg::line_entry_type rd_data
);
   import pge_pkg::*;

   line_entry_type line_mem [DEPTH];
   line_entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read with write-first forwarding on an address match.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
